// ===== src/sacmc_pkg.sv =====
// ----------------------------------------------------------------------------
// sacmc_pkg
// Shared types and constants for the set-associative cache miss classifier.
// ----------------------------------------------------------------------------
package sacmc_pkg;

    // cache geometry
    localparam int SETS_MAX  = 16;
    localparam int SET_W     = 4;
    localparam int WAYS_MAX  = 8;
    localparam int WAY_W     = 3;
    localparam int WAY_CNT_W = 4;
    localparam int RANK_W    = 3;
    localparam logic [RANK_W-1:0] RANK_TOP = 3'd7;

    // replacement random source
    localparam int LFSR_W    = 16;
    localparam int MOD_CNT_W = 4;

    // statistics
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SET_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd3;

    localparam int SCL_W    = 3;
    localparam int POLICY_W = 2;
    localparam logic [SCL_W-1:0]     SCL_RESET    = 3'd2;
    localparam logic [WAY_CNT_W-1:0] WAYS_RESET   = 4'd4;
    localparam logic [LFSR_W-1:0]    SEED_RESET   = 16'd1;

    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd1;
    localparam logic [POLICY_W-1:0] POL_RAND = 2'd2;

    // access classification
    localparam int OUTCOME_W = 2;
    localparam logic [OUTCOME_W-1:0] OUT_HIT  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_COMP = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_CONF = 2'd2;

    // output tdata: set, way, three counters
    localparam int M_DATA_RAW_W = SET_W + WAY_W + 3 * CNT_W;
    localparam int M_DATA_W     = ((M_DATA_RAW_W + 7) / 8) * 8;

    typedef logic [WAYS_MAX-1:0][RANK_W-1:0] t_rank_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic mod_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic rand_conflict;
        logic mod_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/sacmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacmc_ctrl
// Sequencer for one access: accept, tag check, optional victim draw, commit.
// ----------------------------------------------------------------------------
module sacmc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    output sacmc_pkg::t_dp_cmd o_cmd,
    input  sacmc_pkg::t_dp_sts i_sts
);

    sacmc_pkg::t_state r_state;
    sacmc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacmc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sacmc_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = sacmc_pkg::ST_CHECK;
                end
            end
            sacmc_pkg::ST_CHECK: begin
                n_state = i_sts.rand_conflict ? sacmc_pkg::ST_MOD : sacmc_pkg::ST_WRITE;
            end
            sacmc_pkg::ST_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = sacmc_pkg::ST_WRITE;
                end
            end
            sacmc_pkg::ST_WRITE: begin
                if (i_sts.out_free) begin
                    n_state = sacmc_pkg::ST_IDLE;
                end
            end
            default: n_state = sacmc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            sacmc_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load      = i_s_axis_tvalid;
            end
            sacmc_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            sacmc_pkg::ST_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            sacmc_pkg::ST_WRITE: begin
                // hold until the output register can take the result
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/sacmc_dp.sv =====
// ----------------------------------------------------------------------------
// sacmc_dp
// Datapath: config registers, tag/rank row memories, valid bits, victim
// selection, LFSR with bit-serial modulo, counters and output register.
// ----------------------------------------------------------------------------
module sacmc_dp #(
    parameter int ADDR_BITS = 16,
    parameter int S_DATA_W  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sacmc_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [sacmc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [S_DATA_W-1:0]                  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [sacmc_pkg::M_DATA_W-1:0]       o_m_axis_tdata,
    output logic [sacmc_pkg::OUTCOME_W-1:0]      o_m_axis_tuser,
    input  sacmc_pkg::t_dp_cmd                   i_cmd,
    output sacmc_pkg::t_dp_sts                   o_sts
);

    localparam int WAYS_MAX = sacmc_pkg::WAYS_MAX;
    localparam int SET_W    = sacmc_pkg::SET_W;
    localparam int WAY_W    = sacmc_pkg::WAY_W;
    localparam int WCNT_W   = sacmc_pkg::WAY_CNT_W;
    localparam int RANK_W   = sacmc_pkg::RANK_W;
    localparam int CNT_W    = sacmc_pkg::CNT_W;
    localparam int LFSR_W   = sacmc_pkg::LFSR_W;

    typedef logic [WAYS_MAX-1:0][ADDR_BITS-1:0] t_tag_row;

    // configuration
    logic [sacmc_pkg::SCL_W-1:0]    r_scl;
    logic [WCNT_W-1:0]              r_ways_cfg;
    logic [sacmc_pkg::POLICY_W-1:0] r_policy;
    logic [LFSR_W-1:0]              r_lfsr;

    logic [WCNT_W-1:0] ways_act;
    logic [SET_W-1:0]  set_mask;

    // storage
    t_tag_row                         r_tag_mem  [sacmc_pkg::SETS_MAX];
    sacmc_pkg::t_rank_row             r_rank_mem [sacmc_pkg::SETS_MAX];
    logic [sacmc_pkg::SETS_MAX-1:0][WAYS_MAX-1:0] r_valid;
    logic [sacmc_pkg::SETS_MAX-1:0][WAY_W-1:0]    r_fifo;

    // current access
    logic [ADDR_BITS-1:0]            r_addr;
    logic [SET_W-1:0]                r_set;
    t_tag_row                        r_tag_row;
    sacmc_pkg::t_rank_row            r_rank_row;
    logic [sacmc_pkg::OUTCOME_W-1:0] r_outcome;
    logic [WAY_W-1:0]                r_way;

    logic [SET_W-1:0]     set_in;
    logic [ADDR_BITS-1:0] addr_in;

    // check stage
    logic [WAYS_MAX-1:0] in_use;
    logic [WAYS_MAX-1:0] hit_vec;
    logic [WAYS_MAX-1:0] empty_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    empty_way;
    logic [WAY_W-1:0]    lru_way;
    logic [RANK_W-1:0]   lru_best;
    logic [WAY_W-1:0]    fifo_way;
    logic [WAY_W-1:0]    chk_way;
    logic [sacmc_pkg::OUTCOME_W-1:0] chk_outcome;
    logic                lfsr_fb;
    logic [LFSR_W-1:0]   lfsr_next;

    // status to the controller
    logic rand_conflict;
    logic mod_done;
    logic out_free;

    // modulo unit
    logic [LFSR_W-1:0]               r_mod_val;
    logic [WCNT_W-1:0]               r_rem;
    logic [sacmc_pkg::MOD_CNT_W-1:0] r_mod_cnt;
    logic [WCNT_W:0]                 mod_trial;
    logic [WCNT_W-1:0]               rem_next;

    // commit stage
    t_tag_row             n_tag_row;
    sacmc_pkg::t_rank_row n_rank_row;
    logic [RANK_W-1:0]    old_rank;
    logic                 is_fill;
    logic [WAY_W-1:0]     fifo_next;

    // counters and output register
    logic [CNT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_comp_cnt;
    logic [CNT_W-1:0] r_conf_cnt;
    logic [CNT_W-1:0] n_hit_cnt;
    logic [CNT_W-1:0] n_comp_cnt;
    logic [CNT_W-1:0] n_conf_cnt;
    logic             r_m_valid;
    logic [sacmc_pkg::M_DATA_W-1:0]  r_m_data;
    logic [sacmc_pkg::OUTCOME_W-1:0] r_m_user;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb begin
        if (r_ways_cfg == '0) begin
            ways_act = WCNT_W'(1);
        end else if (r_ways_cfg > WCNT_W'(WAYS_MAX)) begin
            ways_act = WCNT_W'(WAYS_MAX);
        end else begin
            ways_act = r_ways_cfg;
        end
        for (int b = 0; b < SET_W; b++) begin
            set_mask[b] = (b < int'(r_scl));
        end
        for (int w = 0; w < WAYS_MAX; w++) begin
            in_use[w] = (w < int'(ways_act));
        end
    end

    assign addr_in = i_s_axis_tdata[ADDR_BITS-1:0];
    assign set_in  = addr_in[SET_W-1:0] & set_mask;

    assign lfsr_fb   = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];
    assign lfsr_next = {lfsr_fb, r_lfsr[LFSR_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl      <= sacmc_pkg::SCL_RESET;
            r_ways_cfg <= sacmc_pkg::WAYS_RESET;
            r_policy   <= sacmc_pkg::POL_LRU;
            r_lfsr     <= sacmc_pkg::SEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sacmc_pkg::REG_SET_LOG2: r_scl      <= i_cfg_wdata[sacmc_pkg::SCL_W-1:0];
                sacmc_pkg::REG_WAYS:     r_ways_cfg <= i_cfg_wdata[WCNT_W-1:0];
                sacmc_pkg::REG_POLICY:   r_policy   <= i_cfg_wdata[sacmc_pkg::POLICY_W-1:0];
                sacmc_pkg::REG_SEED: begin
                    // an all-zero seed would lock the LFSR
                    r_lfsr <= (i_cfg_wdata[LFSR_W-1:0] == '0) ? sacmc_pkg::SEED_RESET
                                                              : i_cfg_wdata[LFSR_W-1:0];
                end
                default: r_scl <= r_scl;
            endcase
        end else if (i_cmd.check && rand_conflict) begin
            r_lfsr <= lfsr_next;
        end
    end

    // ------------------------------------------------------------------
    // row memories: one row per set, read on accept, written on commit
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag_row  <= r_tag_mem[set_in];
            r_rank_row <= r_rank_mem[set_in];
        end
        if (i_cmd.commit) begin
            r_tag_mem[r_set]  <= n_tag_row;
            r_rank_mem[r_set] <= n_rank_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= addr_in;
            r_set  <= set_in;
        end
    end

    // ------------------------------------------------------------------
    // tag check and victim selection
    // ------------------------------------------------------------------
    always_comb begin
        hit_way   = '0;
        empty_way = '0;
        for (int w = WAYS_MAX - 1; w >= 0; w--) begin
            hit_vec[w]   = in_use[w] && r_valid[r_set][w] && (r_tag_row[w] == r_addr);
            empty_vec[w] = in_use[w] && !r_valid[r_set][w];
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (empty_vec[w]) begin
                empty_way = WAY_W'(w);
            end
        end
    end

    // highest rank among ways in use, ties to the lowest way
    always_comb begin
        lru_way  = '0;
        lru_best = r_rank_row[0];
        for (int w = 1; w < WAYS_MAX; w++) begin
            if (in_use[w] && (r_rank_row[w] > lru_best)) begin
                lru_best = r_rank_row[w];
                lru_way  = WAY_W'(w);
            end
        end
    end

    assign fifo_way = ({1'b0, r_fifo[r_set]} >= ways_act) ? '0 : r_fifo[r_set];

    always_comb begin
        rand_conflict = 1'b0;
        if (|hit_vec) begin
            chk_outcome = sacmc_pkg::OUT_HIT;
            chk_way     = hit_way;
        end else if (|empty_vec) begin
            chk_outcome = sacmc_pkg::OUT_COMP;
            chk_way     = empty_way;
        end else begin
            chk_outcome = sacmc_pkg::OUT_CONF;
            case (r_policy)
                sacmc_pkg::POL_FIFO: chk_way = fifo_way;
                sacmc_pkg::POL_RAND: begin
                    chk_way       = '0;
                    rand_conflict = 1'b1;
                end
                default: chk_way = lru_way;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // bit-serial remainder of the new LFSR value by the way count
    // ------------------------------------------------------------------
    assign mod_trial = {r_rem, r_mod_val[LFSR_W-1]};
    assign rem_next  = (mod_trial >= {1'b0, ways_act})
                     ? WCNT_W'(mod_trial - {1'b0, ways_act})
                     : WCNT_W'(mod_trial);
    assign mod_done  = (r_mod_cnt == sacmc_pkg::MOD_CNT_W'(LFSR_W - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_outcome <= chk_outcome;
            r_way     <= chk_way;
            r_mod_val <= lfsr_next;
            r_rem     <= '0;
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod_val <= {r_mod_val[LFSR_W-2:0], 1'b0};
            r_rem     <= rem_next;
            r_mod_cnt <= r_mod_cnt + 1'b1;
            r_way     <= rem_next[WAY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // commit: new row contents, recency, FIFO pointer, counters
    // ------------------------------------------------------------------
    assign is_fill  = (r_outcome == sacmc_pkg::OUT_COMP);
    assign old_rank = r_rank_row[r_way];

    always_comb begin
        n_tag_row        = r_tag_row;
        n_tag_row[r_way] = r_addr;
        for (int v = 0; v < WAYS_MAX; v++) begin
            n_rank_row[v] = r_rank_row[v];
            if (v == int'(r_way)) begin
                n_rank_row[v] = '0;
            end else if (in_use[v] && r_valid[r_set][v]
                         && (is_fill || (r_rank_row[v] < old_rank))
                         && (r_rank_row[v] < sacmc_pkg::RANK_TOP)) begin
                n_rank_row[v] = r_rank_row[v] + 1'b1;
            end
        end
    end

    assign fifo_next = ({1'b0, r_way} + 1'b1 >= ways_act) ? '0 : r_way + 1'b1;

    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_comp_cnt = r_comp_cnt;
        n_conf_cnt = r_conf_cnt;
        case (r_outcome)
            sacmc_pkg::OUT_HIT: begin
                if (r_hit_cnt != sacmc_pkg::CNT_MAX) n_hit_cnt = r_hit_cnt + 1'b1;
            end
            sacmc_pkg::OUT_COMP: begin
                if (r_comp_cnt != sacmc_pkg::CNT_MAX) n_comp_cnt = r_comp_cnt + 1'b1;
            end
            default: begin
                if (r_conf_cnt != sacmc_pkg::CNT_MAX) n_conf_cnt = r_conf_cnt + 1'b1;
            end
        endcase
    end

    assign out_free = !r_m_valid || i_m_axis_tready;

    // member order: rand_conflict, mod_done, out_free
    assign o_sts = {rand_conflict, mod_done, out_free};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fifo     <= '0;
            r_hit_cnt  <= '0;
            r_comp_cnt <= '0;
            r_conf_cnt <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_valid[r_set][r_way] <= 1'b1;
                if ((r_outcome == sacmc_pkg::OUT_CONF) && (r_policy == sacmc_pkg::POL_FIFO)) begin
                    r_fifo[r_set] <= fifo_next;
                end
                r_hit_cnt  <= n_hit_cnt;
                r_comp_cnt <= n_comp_cnt;
                r_conf_cnt <= n_conf_cnt;
                r_m_valid  <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_m_user <= r_outcome;
            r_m_data <= sacmc_pkg::M_DATA_W'({n_conf_cnt, n_comp_cnt, n_hit_cnt, r_way, r_set});
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

`ifndef SYNTHESIS
    // a fill must land on a way that was empty
    a_fill_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_outcome == sacmc_pkg::OUT_COMP)) |-> !r_valid[r_set][r_way])
        else $error("fill targets a valid way");

    // committed way is always inside the ways in use
    a_way_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> ({1'b0, r_way} < ways_act))
        else $error("committed way outside ways in use");

    // partial remainder stays reduced through the draw
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mod_step |-> (r_rem < ways_act))
        else $error("modulo remainder not reduced");

    // the touched line is valid right after commit
    a_line_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid[$past(r_set)][$past(r_way)])
        else $error("committed line not marked valid");
`endif

endmodule

// ===== src/set_assoc_cache_miss_classifier_unit.sv =====
// Each access passes the accept, check and commit states, and its result is
//   held in the output register; a conflict miss under random replacement also
//   passes the bit-serial way draw state. A full output register stalls the
//   commit, and a new access is accepted only once the last one has committed.
// Reset (i_rst_n low, synchronous): valid bits, FIFO pointers, counters and
//   configuration return to defaults at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// set_assoc_cache_miss_classifier_unit
// Classifies each block address as hit, compulsory miss or conflict miss in a
// configurable set-associative cache with LRU, FIFO or random replacement.
// ----------------------------------------------------------------------------
module set_assoc_cache_miss_classifier_unit #(
    parameter int ADDR_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [sacmc_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [sacmc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [((ADDR_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata, // block_address
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // set_index, way_index, hit_total, compulsory_total, conflict_total
    output logic [sacmc_pkg::M_DATA_W-1:0]       o_m_axis_tdata,
    output logic [sacmc_pkg::OUTCOME_W-1:0]      o_m_axis_tuser  // outcome
);

    localparam int S_DATA_W = ((ADDR_BITS + 7) / 8) * 8;

    sacmc_pkg::t_dp_cmd cmd;
    sacmc_pkg::t_dp_sts sts;

    sacmc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (cmd),
        .i_sts           (sts)
    );

    sacmc_dp #(
        .ADDR_BITS (ADDR_BITS),
        .S_DATA_W  (S_DATA_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the set-associative cache miss classifier. A queue of
// block addresses feeds a clocked driver, and a clocked monitor checks every
// result transfer against a cache model kept in the bench. Register settings
// change between drained phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETS_MAX   = sacmc_pkg::SETS_MAX;
    localparam int WAYS_MAX   = sacmc_pkg::WAYS_MAX;
    localparam int SET_W      = sacmc_pkg::SET_W;
    localparam int WAY_W      = sacmc_pkg::WAY_W;
    localparam int WAY_CNT_W  = sacmc_pkg::WAY_CNT_W;
    localparam int RANK_W     = sacmc_pkg::RANK_W;
    localparam int CNT_W      = sacmc_pkg::CNT_W;
    localparam int LFSR_W     = sacmc_pkg::LFSR_W;
    localparam int SCL_W      = sacmc_pkg::SCL_W;
    localparam int POLICY_W   = sacmc_pkg::POLICY_W;
    localparam int OUTCOME_W  = sacmc_pkg::OUTCOME_W;
    localparam int CFG_IDX_W  = sacmc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sacmc_pkg::CFG_DATA_W;
    localparam int M_DATA_W   = sacmc_pkg::M_DATA_W;

    localparam int ADDR_W = 16;
    localparam int LINES  = SETS_MAX * WAYS_MAX;
    // result tdata layout, lowest bit first
    localparam int WAY_LO  = SET_W;
    localparam int HIT_LO  = WAY_LO + WAY_W;
    localparam int COMP_LO = HIT_LO + CNT_W;
    localparam int CONF_LO = COMP_LO + CNT_W;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SET_W-1:0]     set_idx;
        logic [WAY_W-1:0]     way;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     comps;
        logic [CNT_W-1:0]     confs;
    } t_access;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic [ADDR_W-1:0]     s_data      = '0;
    logic                  m_ready     = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [M_DATA_W-1:0]   o_m_axis_tdata;
    logic [OUTCOME_W-1:0]  o_m_axis_tuser;

    set_assoc_cache_miss_classifier_unit #(.ADDR_BITS(ADDR_W)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_idx),
        .i_cfg_wdata     (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // block_address
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // set_index, way_index, hit_total, compulsory_total, conflict_total
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)   // outcome
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // cache model
    logic [SCL_W-1:0]     m_scl;
    logic [WAY_CNT_W-1:0] m_ways;
    logic [POLICY_W-1:0]  m_pol;
    logic                 line_ok   [LINES];
    logic [ADDR_W-1:0]    line_addr [LINES];
    logic [RANK_W-1:0]    age       [LINES];
    logic [WAY_W-1:0]     rr_ptr    [SETS_MAX];
    logic [LFSR_W-1:0]    lfsr;
    logic [CNT_W-1:0]     hits_c, comps_c, confs_c;

    logic [ADDR_W-1:0] addr_q[$];
    t_access           results_due[$];
    t_access           seen_res, want_res;
    logic              s_fire = 1'b0;
    int snd_idle = 0, rcv_idle = 0;
    int hold_asked = 0, hold_served = 0, hold_left = 0;
    int mismatches = 0, n_results = 0, n_writes = 0;
    int n_hit = 0, n_comp = 0, n_conf = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == sacmc_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    // way w becomes most recent; others below its old rank (all, on fill) age
    function automatic void age_ways(input int base, input int ways, input int w,
                                     input logic fill);
        logic [RANK_W-1:0] old;
        int v;
        old = age[base + w];
        for (v = 0; v < ways; v++) begin
            if (v != w && line_ok[base + v] && (fill || age[base + v] < old) &&
                age[base + v] < sacmc_pkg::RANK_TOP)
                age[base + v] = age[base + v] + 1'b1;
        end
        age[base + w] = '0;
    endfunction

    function automatic t_access classify_access(input logic [ADDR_W-1:0] addr);
        t_access r;
        int sets, ways, set, base, w, vict;
        logic found, empty;
        logic [RANK_W-1:0] best;
        sets = 1 << m_scl;
        if (sets > SETS_MAX) sets = SETS_MAX;
        ways = int'(m_ways);
        if (ways == 0) ways = 1;
        if (ways > WAYS_MAX) ways = WAYS_MAX;
        set   = int'(addr) % sets;
        base  = set * WAYS_MAX;
        found = 1'b0;
        empty = 1'b0;
        vict  = 0;
        for (w = 0; w < ways && !found; w++) begin
            if (line_ok[base + w] && line_addr[base + w] == addr) begin
                found = 1'b1;
                vict  = w;
            end
        end
        if (found) begin
            age_ways(base, ways, vict, 1'b0);
            hits_c    = bump(hits_c);
            r.outcome = sacmc_pkg::OUT_HIT;
        end else begin
            for (w = 0; w < ways && !empty; w++) begin
                if (!line_ok[base + w]) begin
                    empty = 1'b1;
                    vict  = w;
                end
            end
            if (empty) begin
                age_ways(base, ways, vict, 1'b1);
                line_ok[base + vict]   = 1'b1;
                line_addr[base + vict] = addr;
                comps_c   = bump(comps_c);
                r.outcome = sacmc_pkg::OUT_COMP;
            end else begin
                if (m_pol == sacmc_pkg::POL_FIFO) begin
                    vict = int'(rr_ptr[set]);
                    if (vict >= ways) vict = 0;
                    rr_ptr[set] = (vict + 1 >= ways) ? '0 : WAY_W'(vict + 1);
                end else if (m_pol == sacmc_pkg::POL_RAND) begin
                    lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
                    vict = int'(lfsr) % ways;
                end else begin
                    // LRU, and the unused policy code too
                    best = age[base];
                    vict = 0;
                    for (w = 1; w < ways; w++) begin
                        if (age[base + w] > best) begin
                            best = age[base + w];
                            vict = w;
                        end
                    end
                end
                age_ways(base, ways, vict, 1'b0);
                line_addr[base + vict] = addr;
                confs_c   = bump(confs_c);
                r.outcome = sacmc_pkg::OUT_CONF;
            end
        end
        r.set_idx = SET_W'(set);
        r.way     = WAY_W'(vict);
        r.hits    = hits_c;
        r.comps   = comps_c;
        r.confs   = confs_c;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] want,
                                   input logic [CNT_W-1:0] seen);
        mismatches++;
        $display("[%0t] result %0d: %s expected %0h got %0h",
                 $time, n_results, what, want, seen);
    endtask

    // result monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && o_s_axis_tready;
            if (o_m_axis_tvalid && m_ready) begin
                seen_res.outcome = o_m_axis_tuser;
                seen_res.set_idx = o_m_axis_tdata[SET_W-1:0];
                seen_res.way     = o_m_axis_tdata[WAY_LO +: WAY_W];
                seen_res.hits    = o_m_axis_tdata[HIT_LO +: CNT_W];
                seen_res.comps   = o_m_axis_tdata[COMP_LO +: CNT_W];
                seen_res.confs   = o_m_axis_tdata[CONF_LO +: CNT_W];
                if (results_due.size() == 0) begin
                    report_mismatch("unrequested result, hit_total", '0, seen_res.hits);
                end else begin
                    want_res = results_due.pop_front();
                    if (seen_res.outcome != want_res.outcome)
                        report_mismatch("outcome", CNT_W'(want_res.outcome),
                                        CNT_W'(seen_res.outcome));
                    if (seen_res.set_idx != want_res.set_idx)
                        report_mismatch("set_index", CNT_W'(want_res.set_idx),
                                        CNT_W'(seen_res.set_idx));
                    if (seen_res.way != want_res.way)
                        report_mismatch("way_index", CNT_W'(want_res.way),
                                        CNT_W'(seen_res.way));
                    if (seen_res.hits != want_res.hits)
                        report_mismatch("hit_total", want_res.hits, seen_res.hits);
                    if (seen_res.comps != want_res.comps)
                        report_mismatch("compulsory_total", want_res.comps, seen_res.comps);
                    if (seen_res.confs != want_res.confs)
                        report_mismatch("conflict_total", want_res.confs, seen_res.confs);
                end
                case (seen_res.outcome)
                    sacmc_pkg::OUT_HIT:  n_hit++;
                    sacmc_pkg::OUT_COMP: n_comp++;
                    default:             n_conf++;
                endcase
                n_results++;
            end
            if (s_valid && o_s_axis_tready)
                results_due.push_back(classify_access(s_data));
        end
    end

    // address driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (addr_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
                s_data  <= addr_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            sacmc_pkg::REG_SET_LOG2: m_scl  = val[SCL_W-1:0];
            sacmc_pkg::REG_WAYS:     m_ways = val[WAY_CNT_W-1:0];
            sacmc_pkg::REG_POLICY:   m_pol  = val[POLICY_W-1:0];
            default:                 lfsr   = (val == '0) ? LFSR_W'(1) : val;
        endcase
        n_writes++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // random upper bits above the register field, half of the time
    function automatic logic [CFG_DATA_W-1:0] noisy(input logic [CFG_DATA_W-1:0] field,
                                                    input logic [CFG_DATA_W-1:0] mask);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
        return (junk & ~mask) | (field & mask);
    endfunction

    task automatic send(input logic [ADDR_W-1:0] a);
        addr_q.push_back(a);
    endtask

    // sender pauses until every outstanding result is back
    task automatic wait_idle();
        while (addr_q.size() != 0 || s_valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (25) @(negedge i_clk);
    endtask

    // working set sized to the current geometry, with reuse and some noise
    task automatic gen_batch(input int n);
        logic [ADDR_W-1:0] pool[$];
        logic [ADDR_W-1:0] recent[$];
        logic [ADDR_W-1:0] a;
        int sets, ways, psize, k, pick;
        sets = 1 << ((m_scl > 4) ? 4 : int'(m_scl));
        ways = (m_ways == 0) ? 1 : ((m_ways > WAYS_MAX) ? WAYS_MAX : int'(m_ways));
        psize = sets * ways + $urandom_range(sets * ways);
        for (k = 0; k < psize; k++)
            pool.push_back(ADDR_W'($urandom));
        pool[0] = '0;
        pool[psize - 1] = '1;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 35 && recent.size() != 0)
                a = recent[$urandom_range(recent.size() - 1)];
            else if (pick < 88)
                a = pool[$urandom_range(psize - 1)];
            else
                a = ADDR_W'($urandom);
            recent.push_back(a);
            if (recent.size() > 6) void'(recent.pop_front());
            send(a);
        end
    endtask

    task automatic model_reset();
        int k;
        m_scl  = sacmc_pkg::SCL_RESET;
        m_ways = sacmc_pkg::WAYS_RESET;
        m_pol  = sacmc_pkg::POL_LRU;
        lfsr   = sacmc_pkg::SEED_RESET;
        hits_c = '0;
        comps_c = '0;
        confs_c = '0;
        for (k = 0; k < LINES; k++) begin
            line_ok[k]   = 1'b0;
            line_addr[k] = '0;
            age[k]       = '0;
        end
        for (k = 0; k < SETS_MAX; k++)
            rr_ptr[k] = '0;
    endtask

    initial begin
        int seg, scl_v, ways_v, seed_v;
        model_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle = 23;
        rcv_idle = 46;

        // defaults: 4 sets, 4 ways, LRU; fill set 0, then evict
        send(16'h0000); send(16'hFFFF); send(16'h0000);
        send(16'h0004); send(16'h0008); send(16'h000C);
        send(16'h0010); send(16'h0004); send(16'h0014);
        wait_idle();
        write_reg(sacmc_pkg::REG_POLICY, CFG_DATA_W'(sacmc_pkg::POL_FIFO));
        send(16'h0018); send(16'h001C); send(16'h0020);
        wait_idle();
        // zero seed is taken as one
        write_reg(sacmc_pkg::REG_POLICY, CFG_DATA_W'(sacmc_pkg::POL_RAND));
        write_reg(sacmc_pkg::REG_SEED, 16'h0000);
        send(16'h0024); send(16'h0028);
        wait_idle();
        write_reg(sacmc_pkg::REG_POLICY, 16'h0003);
        send(16'h002C);
        wait_idle();
        // zero ways acts as one way
        write_reg(sacmc_pkg::REG_WAYS, 16'h0000);
        send(16'h0000); send(16'h0030);
        wait_idle();
        // oversized set and way counts are capped
        write_reg(sacmc_pkg::REG_WAYS, 16'h000F);
        write_reg(sacmc_pkg::REG_SET_LOG2, 16'h0007);
        send(16'h0F0F); send(16'h001F); send(16'h0000);
        wait_idle();
        // back to the reset geometry: old lines still there
        write_reg(sacmc_pkg::REG_WAYS, CFG_DATA_W'(sacmc_pkg::WAYS_RESET));
        write_reg(sacmc_pkg::REG_SET_LOG2, CFG_DATA_W'(sacmc_pkg::SCL_RESET));
        write_reg(sacmc_pkg::REG_SEED, 16'hFFFF);
        send(16'h0004); send(16'h0FFF);
        wait_idle();

        for (seg = 0; seg < 24; seg++) begin
            if (seg == 8) begin
                snd_idle = 46;
                rcv_idle = 23;
            end else if (seg == 16) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            case (seg % 4)
                0: begin scl_v = 0; ways_v = 1; end
                1: begin scl_v = 4; ways_v = 8; end
                default: begin
                    scl_v  = $urandom_range(7);
                    ways_v = $urandom_range(15);
                end
            endcase
            seed_v = (seg % 6 == 0) ? 16'hFFFF : $urandom_range(65535);
            write_reg(sacmc_pkg::REG_SET_LOG2, noisy(CFG_DATA_W'(scl_v), 16'h0007));
            write_reg(sacmc_pkg::REG_WAYS, noisy(CFG_DATA_W'(ways_v), 16'h000F));
            write_reg(sacmc_pkg::REG_POLICY, noisy(CFG_DATA_W'(seg % 3), 16'h0003));
            write_reg(sacmc_pkg::REG_SEED, CFG_DATA_W'(seed_v));
            if (seg % 5 == 4)
                write_reg(sacmc_pkg::REG_POLICY,
                          noisy(CFG_DATA_W'($urandom_range(3)), 16'h0003));
            gen_batch(70);
            if (seg % 8 == 1) hold_asked++;
            wait_idle();
        end

        $display("Checked %0d results over %0d register writes: %0d hits,",
                 n_results, n_writes, n_hit);
        $display("%0d compulsory, %0d conflict; three idle mixes, %0d receiver hold-offs",
                 n_comp, n_conf, hold_served);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d results still outstanding", results_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== set_assoc_cache_miss_classifier_unit.f =====
src/sacmc_pkg.sv
src/sacmc_ctrl.sv
src/sacmc_dp.sv
src/set_assoc_cache_miss_classifier_unit.sv
test/tb.sv
